// ----- design/owik_pkg.sv -----
// ----------------------------------------------------------------------------
// owik_pkg: shared types, constants and helper functions
// Word formats, matrix coefficients, the arctangent and gain tables, and the
// register defaults of the omni-wheel inverse kinematics block.
// ----------------------------------------------------------------------------
package owik_pkg;

  // Default parameter values
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF  = 16;

  // Datapath widths
  localparam int CS_W   = 34;            // Q30 cos/sin and CORDIC x/y
  localparam int MAT_W  = 36;            // matrix entries
  localparam int PROD_W = 52;            // entry times velocity
  localparam int LEV_W  = 33;            // lever arm times yaw rate
  localparam int NUM_W  = 50;            // row sum, Q42
  localparam int MAG_W  = 48;            // row sum magnitude, one divider cell per bit
  localparam int D_W    = 26;            // radius << 10
  localparam int RW     = D_W + 1;       // divider partial remainder
  localparam int CM_W   = 29;            // clamped rad/s magnitude
  localparam int RPM_W  = 61;            // clamped magnitude times rpm factor
  localparam int WHEELS = 3;

  // Matrix coefficients, Q30
  localparam logic signed [31:0] K_HALF  = 32'sd536870912;
  localparam logic signed [31:0] K_S3H   = 32'sd929887263;
  localparam logic signed [31:0] K_SKEW  = 32'sd3435974;
  localparam logic signed [31:0] K_C2S   = 32'sd500115656;
  localparam logic signed [31:0] K_C2C   = 32'sd950160583;
  localparam logic signed [31:0] K_C3S   = 32'sd625175440;
  localparam logic signed [31:0] K_C3C   = 32'sd872964988;
  localparam logic signed [31:0] K_ZERO  = 32'sd0;

  // rpm per rad/s, Q28
  localparam logic [31:0] RPM_Q28 = 32'd2563369783;

  // Register defaults
  localparam logic [15:0] LEVER_RST  = 16'd9830;
  localparam logic [15:0] RADIUS_RST = 16'd3277;

  typedef logic signed [CS_W-1:0]  cs_t;
  typedef logic signed [MAT_W-1:0] mat_t;

  typedef enum logic [1:0] {
    QUAD_0, QUAD_1, QUAD_2, QUAD_3
  } quad_t;

  typedef enum logic [2:0] {
    REG_MODE, REG_LEVER_ONE, REG_LEVER_TWO, REG_LEVER_THREE,
    REG_RADIUS_ONE, REG_RADIUS_TWO, REG_RADIUS_THREE
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic        [15:0] heading;
  } owik_in_t;

  typedef struct packed {
    logic signed [31:0] wheel_one_rads;
    logic signed [31:0] wheel_two_rads;
    logic signed [31:0] wheel_three_rads;
    logic signed [31:0] wheel_one_rpm;
    logic signed [31:0] wheel_two_rpm;
    logic signed [31:0] wheel_three_rpm;
  } owik_out_t;

  // Command carried alongside the rotation
  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    quad_t              quad;
  } cmd_t;

  // One wheel's state in the divider chain
  typedef struct packed {
    logic [MAG_W-1:0] num;
    logic [RW-1:0]    rem;
    logic [MAG_W-1:0] quo;
    logic [D_W-1:0]   dvs;
    logic             neg;
  } div_lane_t;

  // Arctangent of 2^-i in 2^-32 turn
  function automatic logic [31:0] atan_turn32(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Arctangent rounded half up to the angle resolution
  function automatic logic [31:0] atan_step(input int ab, input int i);
    logic [32:0] s;
    s = {1'b0, atan_turn32(i)} + (33'd1 << (31 - ab));
    return 32'(s >> (32 - ab));
  endfunction

  // CORDIC gain in Q30 for the iteration count
  function automatic cs_t gain_q30(input int it);
    cs_t r;
    case (it)
      8:  r = CS_W'(652039507);
      9:  r = CS_W'(652034533);
      10: r = CS_W'(652033289);
      11: r = CS_W'(652032978);
      12: r = CS_W'(652032900);
      13: r = CS_W'(652032881);
      14: r = CS_W'(652032876);
      15: r = CS_W'(652032875);
      default: r = CS_W'(652032874);
    endcase
    return r;
  endfunction

  // Q30 product, rounded half up
  function automatic cs_t mul_q30(input logic signed [31:0] k, input cs_t v);
    logic signed [65:0] p;
    p = 66'(k) * 66'(v);
    p = p + (66'sd1 <<< 29);
    return CS_W'(p >>> 30);
  endfunction

endpackage

// ----- design/omni_wheel_inverse_kinematics.sv -----
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics: three-wheel omni inverse kinematics
// Body velocity command and heading in, wheel rad/s and rpm out, fixed point.
// ----------------------------------------------------------------------------
// The block is a pipeline that takes one command word per clock unless stalled
// and returns one result word per command, in order. Its stages are one input
// stage, one CORDIC cell per iteration, three matrix stages, three row-sum
// stages, one restoring-divider cell per bit of the 48-bit row magnitude, and
// three rpm and saturation stages. A skid register at the output lets the
// pipeline keep taking words while a result waits; it stalls only when both
// output registers are full. The configuration registers may be written at
// any time the pipeline is empty; cfg_ready is always high and writes to
// unknown indexes are dropped.
// ----------------------------------------------------------------------------
module omni_wheel_inverse_kinematics
  import owik_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  owik_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output owik_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AB = ANGLE_BITS;
  localparam int IT = TRIG_ITERATIONS;
  localparam int ZW = AB + 1;

  // configuration registers
  logic        calibrated_mode;
  logic [15:0] lever  [WHEELS];
  logic [15:0] radius [WHEELS];

  logic en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated_mode <= 1'b0;
      for (int k = 0; k < WHEELS; k++) begin
        lever[k]  <= LEVER_RST;
        radius[k] <= RADIUS_RST;
      end
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:         calibrated_mode <= cfg_data[0];
        REG_LEVER_ONE:    lever[0]  <= cfg_data;
        REG_LEVER_TWO:    lever[1]  <= cfg_data;
        REG_LEVER_THREE:  lever[2]  <= cfg_data;
        REG_RADIUS_ONE:   radius[0] <= cfg_data;
        REG_RADIUS_TWO:   radius[1] <= cfg_data;
        REG_RADIUS_THREE: radius[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: quadrant and residue of the heading
  logic [AB+15:0] h_ext;
  logic [AB-1:0]  ang, ang_plus, resid;
  logic [1:0]     quad_bits;
  cmd_t           cmd_next;

  assign in_ready  = en;
  assign h_ext     = {in_data.heading, AB'(0)};
  assign ang       = h_ext[AB+15:16];
  assign ang_plus  = ang + (AB'(1) << (AB - 3));
  assign quad_bits = ang_plus[AB-1 -: 2];
  assign resid     = ang - {quad_bits, (AB-2)'(0)};

  always_comb begin
    cmd_next.vel_x    = in_data.vel_x;
    cmd_next.vel_y    = in_data.vel_y;
    cmd_next.yaw_rate = in_data.yaw_rate;
    cmd_next.quad     = quad_t'(quad_bits);
  end

  logic                 cv [IT+1];
  cmd_t                 cc [IT+1];
  cs_t                  cx [IT+1];
  cs_t                  cy [IT+1];
  logic signed [ZW-1:0] cz [IT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc[0] <= cmd_next;
      cx[0] <= gain_q30(IT);
      cy[0] <= '0;
      cz[0] <= ZW'($signed(resid));
    end
  end

  // CORDIC chain
  for (genvar i = 0; i < IT; i++) begin : g_cordic
    owik_cordic_cell #(
      .ANGLE_BITS(AB),
      .STEP      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[i]),
      .in_cmd   (cc[i]),
      .in_x     (cx[i]),
      .in_y     (cy[i]),
      .in_z     (cz[i]),
      .out_valid(cv[i+1]),
      .out_cmd  (cc[i+1]),
      .out_x    (cx[i+1]),
      .out_y    (cy[i+1]),
      .out_z    (cz[i+1])
    );
  end

  // wheel matrix
  logic              mv;
  cmd_t              mcmd;
  mat_t [WHEELS-1:0] ma, mb;

  owik_matrix u_matrix (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .calibrated_mode(calibrated_mode),
    .in_valid       (cv[IT]),
    .in_cmd         (cc[IT]),
    .in_x           (cx[IT]),
    .in_y           (cy[IT]),
    .out_valid      (mv),
    .out_cmd        (mcmd),
    .out_a          (ma),
    .out_b          (mb)
  );

  // row sums and divider setup
  logic nv1, nv2, dv0;
  logic signed [PROD_W-1:0] pa [WHEELS];
  logic signed [PROD_W-1:0] pb [WHEELS];
  logic signed [LEV_W-1:0]  pl [WHEELS];
  logic signed [NUM_W-1:0]  num [WHEELS];
  logic [15:0]              rad_eff [WHEELS];
  logic [NUM_W-1:0]         num_abs [WHEELS];

  div_lane_t [WHEELS-1:0] dl [MAG_W+1];
  logic                   dv [MAG_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nv1 <= 1'b0;
      nv2 <= 1'b0;
      dv0 <= 1'b0;
    end else if (en) begin
      nv1 <= mv;
      nv2 <= nv1;
      dv0 <= nv2;
    end
  end

  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      rad_eff[k] = (radius[k] == '0) ? 16'd1 : radius[k];
      num_abs[k] = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEELS; k++) begin
        pa[k]  <= PROD_W'(ma[k]) * PROD_W'(mcmd.vel_x);
        pb[k]  <= PROD_W'(mb[k]) * PROD_W'(mcmd.vel_y);
        pl[k]  <= LEV_W'($signed({1'b0, lever[k]})) * LEV_W'(mcmd.yaw_rate);
        num[k] <= NUM_W'(pa[k]) + NUM_W'(pb[k]) + (NUM_W'(pl[k]) <<< 14);
        // magnitude plus half the divisor for round-to-nearest
        dl[0][k].num <= MAG_W'(num_abs[k]) + MAG_W'({rad_eff[k], 9'd0});
        dl[0][k].rem <= '0;
        dl[0][k].quo <= '0;
        dl[0][k].dvs <= {rad_eff[k], 10'd0};
        dl[0][k].neg <= num[k][NUM_W-1];
      end
    end
  end

  assign dv[0] = dv0;

  // divider chain
  for (genvar j = 0; j < MAG_W; j++) begin : g_div
    owik_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[j]),
      .in_lane  (dl[j]),
      .out_valid(dv[j+1]),
      .out_lane (dl[j+1])
    );
  end

  // rad/s saturation, rpm scaling
  localparam logic [MAG_W-1:0] Q_MAX  = MAG_W'(32'h7FFFFFFF);
  localparam logic [MAG_W-1:0] Q_MIN  = MAG_W'(33'h080000000);
  localparam logic [MAG_W-1:0] Q_CLMP = MAG_W'(1) << 28;

  logic rv1, rv2, rv3;
  logic signed [31:0] rads1 [WHEELS];
  logic signed [31:0] rads2 [WHEELS];
  logic signed [31:0] rads3 [WHEELS];
  logic signed [31:0] rpm3  [WHEELS];
  logic [CM_W-1:0]    cm1   [WHEELS];
  logic [RPM_W-1:0]   prod2 [WHEELS];
  logic               neg1  [WHEELS];
  logic               neg2  [WHEELS];
  logic [32:0]        rr    [WHEELS];
  logic [MAG_W-1:0]   q_end [WHEELS];

  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      q_end[k] = dl[MAG_W][k].quo;
      rr[k]    = 33'((prod2[k] + (RPM_W'(1) << 27)) >> 28);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv1 <= 1'b0;
      rv2 <= 1'b0;
      rv3 <= 1'b0;
    end else if (en) begin
      rv1 <= dv[MAG_W];
      rv2 <= rv1;
      rv3 <= rv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEELS; k++) begin
        // stage 1: signed rad/s and clamped magnitude
        neg1[k] <= dl[MAG_W][k].neg;
        if (dl[MAG_W][k].neg) begin
          rads1[k] <= (q_end[k] > Q_MIN) ? 32'sh80000000 : -$signed(q_end[k][31:0]);
        end else begin
          rads1[k] <= (q_end[k] > Q_MAX) ? 32'sh7FFFFFFF : $signed(q_end[k][31:0]);
        end
        cm1[k] <= (q_end[k] > Q_CLMP) ? CM_W'(Q_CLMP) : q_end[k][CM_W-1:0];
        // stage 2: rpm product
        neg2[k]  <= neg1[k];
        rads2[k] <= rads1[k];
        prod2[k] <= RPM_W'(cm1[k]) * RPM_W'(RPM_Q28);
        // stage 3: round and saturate rpm
        rads3[k] <= rads2[k];
        if (neg2[k]) begin
          rpm3[k] <= (rr[k] > 33'h080000000) ? 32'sh80000000 : -$signed(rr[k][31:0]);
        end else begin
          rpm3[k] <= (rr[k] > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(rr[k][31:0]);
        end
      end
    end
  end

  owik_out_t p_data;

  always_comb begin
    p_data.wheel_one_rads   = rads3[0];
    p_data.wheel_two_rads   = rads3[1];
    p_data.wheel_three_rads = rads3[2];
    p_data.wheel_one_rpm    = rpm3[0];
    p_data.wheel_two_rpm    = rpm3[1];
    p_data.wheel_three_rpm  = rpm3[2];
  end

  // output register with skid word
  logic      skid_valid;
  owik_out_t skid_data;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (rv3) begin
      if (out_valid && !out_ready) begin
        skid_data  <= p_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= p_data;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/owik_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// owik_cordic_cell: one rotation step of the heading CORDIC
// Rotates x/y by the fixed arctangent of this step toward zero residue and
// hands the command word on to the next cell.
// ----------------------------------------------------------------------------
module owik_cordic_cell
  import owik_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int STEP       = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  cmd_t                       in_cmd,
  input  cs_t                        in_x,
  input  cs_t                        in_y,
  input  logic signed [ANGLE_BITS:0] in_z,
  output logic                       out_valid,
  output cmd_t                       out_cmd,
  output cs_t                        out_x,
  output cs_t                        out_y,
  output logic signed [ANGLE_BITS:0] out_z
);

  localparam int ZW = ANGLE_BITS + 1;
  localparam logic [31:0] T_FULL = atan_step(ANGLE_BITS, STEP);
  localparam logic signed [ZW-1:0] T = T_FULL[ZW-1:0];

  cs_t dx, dy;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // rotate toward zero residue
  always_ff @(posedge clk) begin
    if (en) begin
      out_cmd <= in_cmd;
      if (in_z >= 0) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - T;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + T;
      end
    end
  end

endmodule

// ----- design/owik_matrix.sv -----
// ----------------------------------------------------------------------------
// owik_matrix: quadrant fold and wheel matrix
// Maps the CORDIC result back to cos/sin of the full heading, then forms the
// x and y columns of the ideal or calibrated wheel matrix in three stages.
// ----------------------------------------------------------------------------
module owik_matrix
  import owik_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    calibrated_mode,
  input  logic                    in_valid,
  input  cmd_t                    in_cmd,
  input  cs_t                     in_x,
  input  cs_t                     in_y,
  output logic                    out_valid,
  output cmd_t                    out_cmd,
  output mat_t [WHEELS-1:0]       out_a,
  output mat_t [WHEELS-1:0]       out_b
);

  logic v1, v2;
  cmd_t cmd1, cmd2;
  cs_t  c1, s1, c2, s2;
  cs_t  c_next, s_next;
  cs_t  ec, es, ps, qc, qs, pc, rs, sc, ss, rc;
  logic signed [31:0] k_e, k_p, k_q, k_r, k_s;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // quadrant fold
  always_comb begin
    case (in_cmd.quad)
      QUAD_0: begin c_next = in_x;  s_next = in_y;  end
      QUAD_1: begin c_next = -in_y; s_next = in_x;  end
      QUAD_2: begin c_next = -in_x; s_next = -in_y; end
      default: begin c_next = in_y; s_next = -in_x; end
    endcase
  end

  // coefficient set
  always_comb begin
    if (calibrated_mode) begin
      k_e = K_SKEW; k_p = K_C2S; k_q = K_C2C; k_r = K_C3S; k_s = K_C3C;
    end else begin
      k_e = K_ZERO; k_p = K_HALF; k_q = K_S3H; k_r = K_HALF; k_s = K_S3H;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: fold
      cmd1 <= in_cmd;
      c1   <= c_next;
      s1   <= s_next;
      // stage 2: coefficient products
      cmd2 <= cmd1;
      c2   <= c1;
      s2   <= s1;
      ec   <= mul_q30(k_e, c1);
      es   <= mul_q30(k_e, s1);
      ps   <= mul_q30(k_p, s1);
      qc   <= mul_q30(k_q, c1);
      qs   <= mul_q30(k_q, s1);
      pc   <= mul_q30(k_p, c1);
      rs   <= mul_q30(k_r, s1);
      sc   <= mul_q30(k_s, c1);
      ss   <= mul_q30(k_s, s1);
      rc   <= mul_q30(k_r, c1);
      // stage 3: matrix entries
      out_cmd  <= cmd2;
      out_a[0] <= -mat_t'(s2) - mat_t'(ec);
      out_b[0] <= mat_t'(c2) - mat_t'(es);
      out_a[1] <= mat_t'(ps) - mat_t'(qc);
      out_b[1] <= -mat_t'(qs) - mat_t'(pc);
      out_a[2] <= mat_t'(rs) + mat_t'(sc);
      out_b[2] <= mat_t'(ss) - mat_t'(rc);
    end
  end

endmodule

// ----- design/owik_div_cell.sv -----
// ----------------------------------------------------------------------------
// owik_div_cell: one restoring-division step for all three wheels
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module owik_div_cell
  import owik_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  div_lane_t [WHEELS-1:0] in_lane,
  output logic                   out_valid,
  output div_lane_t [WHEELS-1:0] out_lane
);

  div_lane_t [WHEELS-1:0] lane_next;
  logic [RW-1:0] rem_sh [WHEELS];
  logic          fits   [WHEELS];

  // one quotient bit per wheel
  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      rem_sh[k]        = {in_lane[k].rem[RW-2:0], in_lane[k].num[MAG_W-1]};
      fits[k]          = rem_sh[k] >= {1'b0, in_lane[k].dvs};
      lane_next[k]     = in_lane[k];
      lane_next[k].num = {in_lane[k].num[MAG_W-2:0], 1'b0};
      lane_next[k].rem = fits[k] ? rem_sh[k] - {1'b0, in_lane[k].dvs} : rem_sh[k];
      lane_next[k].quo = {in_lane[k].quo[MAG_W-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

// ----- bench/omni_wheel_inverse_kinematics_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics_tb: self-checking bench for omni wheel kinematics
// Drives commands through the valid/ready port and predicts each wheel word
// with a fixed-point model of its own. It compares every output word field
// by field. The run covers both matrix modes, register extremes, a zero
// radius, a dropped register index, output saturation and back pressure.
// ----------------------------------------------------------------------------
module omni_wheel_inverse_kinematics_tb;
  import owik_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;   // index with no register behind it
  localparam int         PIPE_LAT   = 80;     // a little over the pipeline depth

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  owik_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  owik_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Bench copy of the register file
  logic        mode_cal;
  logic [15:0] lever_arm [3];
  logic [15:0] radius [3];

  owik_out_t wheel_words_due[$];
  int        errors = 0;
  bit        idle_on = 1'b0;
  int        hold_cycles = 0;

  // Arctangent of 2^-i in 2^-32 turn
  localparam logic [31:0] ATAN_TURN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  omni_wheel_inverse_kinematics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint q30_const(input longint n, input longint d);
    return ((n <<< 30) + d / 2) / d;
  endfunction

  function automatic longint q30_mul(input longint k, input longint v);
    return (k * v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // CORDIC rotation on a quadrant-reduced heading
  function automatic void heading_trig(input logic [15:0] h, output longint cs,
                                       output longint sn);
    longint x, y, z, dx, dy, t, ru;
    quad_t  q;
    q  = quad_t'(((longint'(h) + 8192) >> 14) & 3);
    ru = (longint'(h) - longint'(q) * 16384) & 16'hFFFF;
    z  = (ru >= 32768) ? ru - 65536 : ru;
    x  = 64'sd652032874;
    y  = 0;
    for (int i = 0; i < 16; i++) begin
      t  = (longint'(ATAN_TURN[i]) + (64'sd1 <<< 15)) >>> 16;
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    case (q)
      QUAD_0: begin cs = x;  sn = y;  end
      QUAD_1: begin cs = -y; sn = x;  end
      QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // One matrix row: speed in rad/s, then rpm, both saturated
  function automatic void wheel_speed(input longint a, input longint b,
                                      input logic [15:0] lev, input logic [15:0] rad,
                                      input longint vx, input longint vy, input longint w,
                                      output logic [31:0] rads, output logic [31:0] rpm);
    longint num, m, d, om, oc, p, r;
    num = a * vx + b * vy + longint'(lev) * w * 16384;
    d   = longint'((rad == 0) ? 16'd1 : rad) <<< 10;
    m   = (num < 0) ? -num : num;
    om  = (m + d / 2) / d;
    if (num < 0) om = -om;
    oc  = (om > (64'sd1 <<< 28)) ? (64'sd1 <<< 28) :
          (om < -(64'sd1 <<< 28)) ? -(64'sd1 <<< 28) : om;
    p   = oc * 64'sd2563369783;
    r   = (((p < 0) ? -p : p) + (64'sd1 <<< 27)) >>> 28;
    if (p < 0) r = -r;
    rads = 32'(clip32(om));
    rpm  = 32'(clip32(r));
  endfunction

  function automatic owik_out_t wheel_words(input owik_in_t c);
    longint cs, sn, vx, vy, w, kh, ks;
    longint a [3];
    longint b [3];
    logic [31:0] rads [3];
    logic [31:0] rpm [3];
    owik_out_t o;
    vx = c.vel_x; vy = c.vel_y; w = c.yaw_rate;
    heading_trig(c.heading, cs, sn);
    if (mode_cal) begin
      ks = q30_const(32, 10000);
      a[0] = -sn - q30_mul(ks, cs);
      b[0] = cs - q30_mul(ks, sn);
      a[1] = q30_mul(q30_const(465769, 1000000), sn) - q30_mul(q30_const(884906, 1000000), cs);
      b[1] = -q30_mul(q30_const(884906, 1000000), sn) - q30_mul(q30_const(465769, 1000000), cs);
      a[2] = q30_mul(q30_const(58224, 100000), sn) + q30_mul(q30_const(813012, 1000000), cs);
      b[2] = q30_mul(q30_const(813012, 1000000), sn) - q30_mul(q30_const(58224, 100000), cs);
    end else begin
      kh = q30_const(1, 2);
      ks = q30_const(866025, 1000000);
      a[0] = -sn;
      b[0] = cs;
      a[1] = q30_mul(kh, sn) - q30_mul(ks, cs);
      b[1] = -q30_mul(ks, sn) - q30_mul(kh, cs);
      a[2] = q30_mul(kh, sn) + q30_mul(ks, cs);
      b[2] = q30_mul(ks, sn) - q30_mul(kh, cs);
    end
    for (int k = 0; k < 3; k++)
      wheel_speed(a[k], b[k], lever_arm[k], radius[k], vx, vy, w, rads[k], rpm[k]);
    o.wheel_one_rads   = rads[0];
    o.wheel_two_rads   = rads[1];
    o.wheel_three_rads = rads[2];
    o.wheel_one_rpm    = rpm[0];
    o.wheel_two_rpm    = rpm[1];
    o.wheel_three_rpm  = rpm[2];
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_cmd(input owik_in_t c);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    wheel_words_due.push_back(wheel_words(c));
  endtask

  task automatic end_cmds();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    end_cmds();
    wait (wheel_words_due.size() == 0);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:         mode_cal = val[0];
      REG_LEVER_ONE:    lever_arm[0] = val;
      REG_LEVER_TWO:    lever_arm[1] = val;
      REG_LEVER_THREE:  lever_arm[2] = val;
      REG_RADIUS_ONE:   radius[0] = val;
      REG_RADIUS_TWO:   radius[1] = val;
      REG_RADIUS_THREE: radius[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic m, input logic [15:0] l0, input logic [15:0] l1,
                          input logic [15:0] l2, input logic [15:0] r0,
                          input logic [15:0] r1, input logic [15:0] r2);
    reg_write(REG_MODE, {15'($urandom), m});
    reg_write(REG_LEVER_ONE, l0);
    reg_write(REG_LEVER_TWO, l1);
    reg_write(REG_LEVER_THREE, l2);
    reg_write(REG_RADIUS_ONE, r0);
    reg_write(REG_RADIUS_TWO, r1);
    reg_write(REG_RADIUS_THREE, r2);
  endtask

  function automatic owik_in_t rand_cmd();
    owik_in_t c;
    c = {$urandom, $urandom};
    // pull some fields to their limits
    if ($urandom_range(0, 7) == 0) c.vel_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(0, 7) == 0) c.vel_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(0, 7) == 0) c.yaw_rate = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(0, 7) == 0) c.heading = 16'($urandom_range(0, 7) * 8192);
    return c;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= idle_on ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $time, field,
             $signed(got), $signed(want));
    errors++;
  endtask

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin
    owik_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (wheel_words_due.size() == 0) begin
        $display("%0t unexpected output word", $time);
        errors++;
      end else begin
        want = wheel_words_due.pop_front();
        if (out_data.wheel_one_rads !== want.wheel_one_rads)
          report_mismatch("wheel_one_rads", out_data.wheel_one_rads, want.wheel_one_rads);
        if (out_data.wheel_two_rads !== want.wheel_two_rads)
          report_mismatch("wheel_two_rads", out_data.wheel_two_rads, want.wheel_two_rads);
        if (out_data.wheel_three_rads !== want.wheel_three_rads)
          report_mismatch("wheel_three_rads", out_data.wheel_three_rads,
                          want.wheel_three_rads);
        if (out_data.wheel_one_rpm !== want.wheel_one_rpm)
          report_mismatch("wheel_one_rpm", out_data.wheel_one_rpm, want.wheel_one_rpm);
        if (out_data.wheel_two_rpm !== want.wheel_two_rpm)
          report_mismatch("wheel_two_rpm", out_data.wheel_two_rpm, want.wheel_two_rpm);
        if (out_data.wheel_three_rpm !== want.wheel_three_rpm)
          report_mismatch("wheel_three_rpm", out_data.wheel_three_rpm, want.wheel_three_rpm);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Field extremes and headings around every quadrant boundary, ideal matrix
  task automatic test_directed_ideal();
    logic [15:0] hd [10] = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd24576,
                             16'd32768, 16'd40960, 16'd49152, 16'd57344, 16'd65535};
    send_cmd('{16'sd0, 16'sd0, 16'sd0, 16'd0});
    send_cmd('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0});
    send_cmd('{16'sh8000, 16'sh8000, 16'sh8000, 16'd65535});
    send_cmd('{16'sh7FFF, 16'sh8000, 16'sd0, 16'd32768});
    foreach (hd[i]) send_cmd('{16'sd4096, -16'sd2048, 16'sd1024, hd[i]});
    drain();
  endtask

  // Calibrated matrix, masked mode bit, dropped index, zero radius, saturation
  task automatic test_special_regs();
    set_regs(1'b1, 16'd9830, 16'd9830, 16'd9830, 16'd3277, 16'd3277, 16'd3277);
    send_cmd('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd12345});
    send_cmd('{16'sd4096, 16'sd4096, -16'sd4096, 16'd49152});
    drain();
    reg_write(REG_MODE, 16'hFFFE);          // only bit zero lands
    reg_write(REG_UNUSED, 16'h0000);        // must leave every register alone
    set_regs(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    drain();
    send_cmd('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0});
    send_cmd('{16'sh8000, 16'sh8000, 16'sh8000, 16'd16384});
    send_cmd('{16'sd1, -16'sd1, 16'sd1, 16'd40000});
    send_cmd('{16'sd0, 16'sd0, 16'sh8000, 16'd100});
    drain();
  endtask

  // Random items under several register settings
  task automatic test_config_sweep();
    for (int s = 0; s < 6; s++) begin
      set_regs(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 3000)),
               16'($urandom_range(20000, 65535)));
      idle_on = s[0];
      send_random(25);
      drain();
    end
  endtask

  // Receiver blocked long enough that the pipeline backs up into the input
  task automatic test_back_pressure();
    idle_on = 1'b0;
    set_regs(1'b1, 16'd9830, 16'd12000, 16'd7000, 16'd3277, 16'd3000, 16'd3500);
    @(posedge clk);
    hold_cycles = 300;
    send_random(150);
    drain();
  endtask

  // Bulk random run: a stretch without idling, then idling on both sides
  task automatic test_random_bulk();
    set_regs(1'b0, 16'd9830, 16'd9830, 16'd9830, 16'd3277, 16'd3277, 16'd3277);
    idle_on = 1'b0;
    send_random(100);
    idle_on = 1'b1;
    send_random(100);
    drain();
    set_regs(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
             16'($urandom_range(1, 65535)));
    send_random(100);
    drain();
  endtask

  initial begin
    mode_cal  = 1'b0;
    lever_arm = '{LEVER_RST, LEVER_RST, LEVER_RST};
    radius    = '{RADIUS_RST, RADIUS_RST, RADIUS_RST};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_ideal();
    test_special_regs();
    test_config_sweep();
    test_back_pressure();
    test_random_bulk();
    repeat (PIPE_LAT) @(posedge clk);
    if (errors == 0 && wheel_words_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/owik_pkg.sv
design/owik_cordic_cell.sv
design/owik_matrix.sv
design/owik_div_cell.sv
design/omni_wheel_inverse_kinematics.sv
bench/omni_wheel_inverse_kinematics_tb.sv
